### design/sdd_pkg.sv
// shared types and constants for the strum direction detector
// no dependencies; imported by sdd_avg_div and strum_direction_detector

package sdd_pkg;

   // scaled sample, block sum, block average and step counter widths
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int AVG_W    = 12;
   localparam int COUNT_W  = 4;

   // configuration register file
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 12;
   localparam int THRESH_W    = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_STEP_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_TRIGGER_COUNT  = 4'd1;

   localparam logic [THRESH_W-1:0] STEP_THRESHOLD_RESET = 12'd100;
   localparam logic [COUNT_W-1:0]  TRIGGER_COUNT_RESET  = 4'd4;
   localparam logic [COUNT_W-1:0]  COUNT_MAX            = 4'hF;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [AVG_W-1:0] avg_type;

endpackage

### design/sdd_avg_div.sv
// block average: signed block sum divided by BLOCK_LEN, truncating toward zero
// depends on sdd_pkg; reciprocal multiply on the magnitude, no divider

module sdd_avg_div import sdd_pkg::*; #(
   parameter int BLOCK_LEN = 10
) (
   input  sum_type sum_i,
   output avg_type avg_o
);

   // magnitude stays below 2^MAG_W, so a shift of MAG_W + log2 gives exact quotients
   localparam int MAG_W     = SUM_W - 1;
   localparam int DIV_SHIFT = MAG_W + $clog2(BLOCK_LEN);
   localparam int RECIP_W   = DIV_SHIFT;
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2**DIV_SHIFT + BLOCK_LEN - 1) / BLOCK_LEN);

   logic [SUM_W-1:0]  sum_neg;
   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [AVG_W:0]    quot;
   logic [AVG_W:0]    quot_neg;

   assign sum_neg  = -sum_i;
   assign mag      = sum_i[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_i[MAG_W-1:0];
   assign prod     = PROD_W'(mag) * PROD_W'(RECIP);
   assign quot     = prod[DIV_SHIFT +: AVG_W+1];
   assign quot_neg = -quot;
   assign avg_o    = sum_i[SUM_W-1] ? quot_neg[AVG_W-1:0] : quot[AVG_W-1:0];

endmodule

### design/strum_direction_detector.sv
// strum direction detector top level: input register, block averaging, step counting
// depends on sdd_pkg and sdd_avg_div
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------------
//   req      | in  | req_tvalid/tready    | tdata: accel_z, button_down, button_index
//   rsp      | out | rsp_tvalid/tready    | tdata: strum_up, note_button
//   csr      | in  | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// one word per cycle sustained while rsp is not stalled: the scaled sample sits in an input
// register, and one pass of logic (block sum add, reciprocal multiply, compare, count
// update) lands in the result register, which drives rsp_tvalid
// a word that fires no strum, or has button_down low, leaves no result; the state still updates
// synchronous active-high reset clears the counters, baseline and both valid flags
// a stalled rsp holds the input stage; req_tready drops only when both stages are full

module strum_direction_detector import sdd_pkg::*; #(
   parameter int BLOCK_LEN = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: accel_z [15:0], button_down [16], button_index [20:17], zeros above
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,
   // rsp_tdata: strum_up [0], note_button [4:1], zeros above
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(BLOCK_LEN);
   localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(BLOCK_LEN - 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] scaled;
      logic                       button_down;
      logic [3:0]                 button_index;
   } sample_type;

   // configuration
   logic [THRESH_W-1:0] step_threshold_ff;
   logic [COUNT_W-1:0]  trigger_count_ff;

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   sample_type  s1_ff, s1_in;
   logic        advance;

   // detector state
   logic [CNT_W-1:0]   sample_cnt_ff, sample_cnt_in;
   sum_type            block_sum_ff, block_sum_in;
   avg_type            prev_avg_ff, prev_avg_in;
   logic               baseline_ff, baseline_in;
   logic [COUNT_W-1:0] down_ff, down_in;
   logic [COUNT_W-1:0] up_ff, up_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       strum_up_ff;
   logic [3:0] note_button_ff;

   // datapath
   logic signed [15:0] accel_z;
   logic [15:0]        accel_biased;
   sum_type            sum_next;
   avg_type            avg;
   logic               block_done;
   logic signed [AVG_W:0] diff_down, diff_up, thresh_ext;
   logic               drop, rise;
   logic [COUNT_W-1:0] down_step, up_step;
   logic               fire, fire_up;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_threshold_ff <= STEP_THRESHOLD_RESET;
         trigger_count_ff  <= TRIGGER_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IDX_STEP_THRESHOLD: step_threshold_ff <= csr_data[THRESH_W-1:0];
            CSR_IDX_TRIGGER_COUNT:  trigger_count_ff  <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // the result register can take a new value when empty or draining
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   // divide by 16 toward zero: bias negatives by 15 before the arithmetic shift
   assign accel_z      = req_tdata[15:0];
   assign accel_biased = accel_z + {12'd0, {4{accel_z[15]}}};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         s1_in.scaled       = accel_biased[15:4];
         s1_in.button_down  = req_tdata[16];
         s1_in.button_index = req_tdata[20:17];
      end
   end

   // block sum and average
   assign sum_next   = block_sum_ff + SUM_W'(s1_ff.scaled);
   assign block_done = (sample_cnt_ff == LAST_SAMPLE);

   sdd_avg_div #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_avg_div (
      .sum_i (sum_next),
      .avg_o (avg)
   );

   // step compare against the previous block average
   assign diff_down  = (AVG_W+1)'(prev_avg_ff) - (AVG_W+1)'(avg);
   assign diff_up    = (AVG_W+1)'(avg) - (AVG_W+1)'(prev_avg_ff);
   assign thresh_ext = $signed({1'b0, step_threshold_ff});
   assign drop       = (diff_down >= thresh_ext);
   assign rise       = (diff_up >= thresh_ext);

   always_comb begin
      down_step = down_ff;
      up_step   = up_ff;
      if (block_done && baseline_ff) begin
         if (drop) begin
            down_step = (down_ff == COUNT_MAX) ? down_ff : down_ff + 1'b1;
            up_step   = (up_ff != '0) ? up_ff - 1'b1 : up_ff;
         end else if (rise) begin
            up_step   = (up_ff == COUNT_MAX) ? up_ff : up_ff + 1'b1;
            down_step = (down_ff != '0) ? down_ff - 1'b1 : down_ff;
         end
      end
   end

   // fire check, down first, once a baseline exists (including the block that sets it)
   always_comb begin
      baseline_in   = baseline_ff | block_done;
      down_in       = down_step;
      up_in         = up_step;
      fire          = 1'b0;
      fire_up       = 1'b0;
      if (baseline_in) begin
         if (down_step >= trigger_count_ff) begin
            down_in = '0;
            fire    = 1'b1;
         end else if (up_step >= trigger_count_ff) begin
            up_in   = '0;
            fire    = 1'b1;
            fire_up = 1'b1;
         end
      end
      sample_cnt_in = block_done ? '0 : sample_cnt_ff + 1'b1;
      block_sum_in  = block_done ? '0 : sum_next;
      prev_avg_in   = block_done ? avg : prev_avg_ff;
   end

   assign rsp_valid_in = advance ? (s1_valid_ff && fire && s1_ff.button_down) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sample_cnt_ff <= '0;
         block_sum_ff  <= '0;
         prev_avg_ff   <= '0;
         baseline_ff   <= 1'b0;
         down_ff       <= '0;
         up_ff         <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && advance) begin
            sample_cnt_ff <= sample_cnt_in;
            block_sum_ff  <= block_sum_in;
            prev_avg_ff   <= prev_avg_in;
            baseline_ff   <= baseline_in;
            down_ff       <= down_in;
            up_ff         <= up_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (advance && s1_valid_ff && fire && s1_ff.button_down) begin
         strum_up_ff    <= fire_up;
         note_button_ff <= s1_ff.button_index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, note_button_ff, strum_up_ff};

endmodule
